>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the UV sensor averaging block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/uvsa_pkg.sv
`default_nettype none
package uvsa_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int CNT_W       = 9;
  localparam int ACC_W       = 20;
  localparam int THR_W       = 12;
  localparam int OUT_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;
  localparam int DIV_W       = ACC_W;
  localparam int DEN_W       = CNT_W;
  localparam int STEP_W      = $clog2(DIV_W);
  localparam int MAX_SAMPLES = 256;
  localparam int MUL_W       = 27;
  localparam int PROD_W      = OUT_W + MUL_W;
  localparam int UV_SHIFT    = 25;
  localparam int UV_W        = PROD_W - UV_SHIFT;

  localparam logic [CNT_W-1:0]     READ_LEN_RST        = CNT_W'(16);
  localparam logic [THR_W-1:0]     ALARM_LEVEL_RST     = THR_W'(1536);
  localparam logic [CNT_W-1:0]     COUNT_MAX           = CNT_W'(MAX_SAMPLES);
  localparam logic [DIV_W-1:0]     AVG_MAX             = DIV_W'(4095);
  localparam logic [UV_W-1:0]      UV_MAX              = UV_W'(2816);
  // Mean to Q4.8 index is mean * 92928 / 40950, taken as mean * UV_MUL >> UV_SHIFT,
  // which floors exactly for every 12-bit mean.
  localparam logic [MUL_W-1:0]     UV_MUL              = MUL_W'(76145208);
  localparam logic [STEP_W-1:0]    DIV_LAST            = STEP_W'(DIV_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_READ_LEN        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LEVEL     = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_SCALE,
    ST_EMIT,
    ST_EMIT_FAIL
  } state_t;

  typedef struct packed {
    logic accum;
    logic clear;
    logic start_avg;
    logic div_step;
    logic scale;
    logic emit_ok;
    logic emit_fail;
  } cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic group_done;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/uvsa_if.sv
`default_nettype none
interface uvsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [uvsa_pkg::SAMPLE_W-1:0] sample;
  logic                          sample_valid;

  modport source (output valid, output sample, output sample_valid, input ready);
  modport sink (input valid, input sample, input sample_valid, output ready);
endinterface

interface uvsa_out_if;
  logic                       valid;
  logic                       ready;
  logic [uvsa_pkg::OUT_W-1:0] average_raw;
  logic [uvsa_pkg::OUT_W-1:0] uvi;
  logic                       alert;
  logic                       failed;

  modport source (output valid, output average_raw, output uvi, output alert,
                  output failed, input ready);
  modport sink (input valid, input average_raw, input uvi, input alert,
                input failed, output ready);
endinterface
`default_nettype wire

>>> rtl/uv_sensor_average_scale_alarm_core.sv
// UV sensor averaging core with threshold alarm.
// Samples arrive on in_ch as valid/ready beats carrying a 12-bit ADC code and
// a flag saying whether the conversion succeeded. Readings leave on out_ch.
// The configuration port writes the group length (index 0) and the alarm level
// (index 1) whenever cfg_we is high; write it only while idle.
// A sample that does not complete a group is added to the sum and yields nothing.
// The sample that completes a group starts a bit-serial restoring division of
// the sum by the group length; ST_SCALE then scales the mean to the UV index
// with a constant multiply, and the reading is loaded into the output register
// from ST_EMIT once that register is free.
// A failed conversion empties the group and moves to ST_EMIT_FAIL, which
// loads a failure reading once the output register is free. While the core
// computes, in_ch.ready is low.
// The output register holds a reading until it is taken, and new samples are
// accepted meanwhile; only the loading of the next reading waits on a stall,
// and in_ch.ready stays low while it waits.
// Synchronous reset empties the group, drops any held reading and restores
// the group length to 16 and the alarm level to 1536.
`default_nettype none
module uv_sensor_average_scale_alarm_core (
  input  wire                              clk,
  input  wire                              rst_n,
  uvsa_in_if.sink                          in_ch,
  uvsa_out_if.source                       out_ch,
  input  wire                              cfg_we,
  input  wire  [uvsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [uvsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  uvsa_pkg::cmd_t    cmd;
  uvsa_pkg::status_t sts;

  uvsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  uvsa_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample       (in_ch.sample),
    .in_sample_valid (in_ch.sample_valid),
    .cmd             (cmd),
    .sts             (sts),
    .out_average_raw (out_ch.average_raw),
    .out_uvi         (out_ch.uvi),
    .out_alert       (out_ch.alert),
    .out_failed      (out_ch.failed)
  );

endmodule
`default_nettype wire

>>> rtl/uvsa_datapath.sv
`default_nettype none
module uvsa_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [uvsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [uvsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire  [uvsa_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire                              in_sample_valid,
  input  uvsa_pkg::cmd_t                   cmd,
  output uvsa_pkg::status_t                sts,
  output logic [uvsa_pkg::OUT_W-1:0]       out_average_raw,
  output logic [uvsa_pkg::OUT_W-1:0]       out_uvi,
  output logic                             out_alert,
  output logic                             out_failed
);

  logic [uvsa_pkg::CNT_W-1:0]   read_len_r;
  logic [uvsa_pkg::THR_W-1:0]   alarm_level_r;
  logic [uvsa_pkg::ACC_W-1:0]   acc_r;
  logic [uvsa_pkg::CNT_W-1:0]   taken_r;
  logic [uvsa_pkg::DIV_W-1:0]   dvd_r;
  logic [uvsa_pkg::DEN_W-1:0]   rem_r;
  logic [uvsa_pkg::DEN_W-1:0]   dsr_r;
  logic [uvsa_pkg::OUT_W-1:0]   avg_r;
  logic [uvsa_pkg::OUT_W-1:0]   uvi_r;
  logic [uvsa_pkg::OUT_W-1:0]   avg_q_r;
  logic [uvsa_pkg::OUT_W-1:0]   uv_q_r;
  logic                         alert_q_r;
  logic                         failed_q_r;

  logic [uvsa_pkg::CNT_W-1:0]   eff_count;
  logic [uvsa_pkg::ACC_W-1:0]   sum;
  logic [uvsa_pkg::CNT_W-1:0]   taken_inc;
  logic [uvsa_pkg::DEN_W:0]     trial;
  logic                         trial_ge;
  logic [uvsa_pkg::DEN_W-1:0]   rem_nxt;
  logic [uvsa_pkg::OUT_W-1:0]   avg_clamped;
  logic [uvsa_pkg::PROD_W-1:0]  product;
  logic [uvsa_pkg::UV_W-1:0]    uv_raw;
  logic [uvsa_pkg::OUT_W-1:0]   uv_clamped;

  always_comb begin
    if (read_len_r == '0) begin
      eff_count = uvsa_pkg::CNT_W'(1);
    end else if (read_len_r > uvsa_pkg::COUNT_MAX) begin
      eff_count = uvsa_pkg::COUNT_MAX;
    end else begin
      eff_count = read_len_r;
    end
  end

  assign sum       = acc_r + uvsa_pkg::ACC_W'(in_sample);
  assign taken_inc = taken_r + uvsa_pkg::CNT_W'(1);

  assign sts.sample_ok  = in_sample_valid;
  assign sts.group_done = (taken_inc >= eff_count);

  // Restoring division, one quotient bit per cycle.
  assign trial    = {rem_r, dvd_r[uvsa_pkg::DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, dsr_r});
  assign rem_nxt  = trial_ge ? uvsa_pkg::DEN_W'(trial - {1'b0, dsr_r})
                             : uvsa_pkg::DEN_W'(trial);

  assign avg_clamped = (dvd_r > uvsa_pkg::AVG_MAX) ? uvsa_pkg::OUT_W'(uvsa_pkg::AVG_MAX)
                                                   : dvd_r[uvsa_pkg::OUT_W-1:0];
  assign product     = uvsa_pkg::PROD_W'(avg_clamped) * uvsa_pkg::PROD_W'(uvsa_pkg::UV_MUL);
  assign uv_raw      = product[uvsa_pkg::PROD_W-1:uvsa_pkg::UV_SHIFT];
  assign uv_clamped  = (uv_raw > uvsa_pkg::UV_MAX) ? uvsa_pkg::OUT_W'(uvsa_pkg::UV_MAX)
                                                   : uv_raw[uvsa_pkg::OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_len_r    <= uvsa_pkg::READ_LEN_RST;
      alarm_level_r <= uvsa_pkg::ALARM_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        uvsa_pkg::REG_READ_LEN: begin
          read_len_r <= cfg_data[uvsa_pkg::CNT_W-1:0];
        end
        uvsa_pkg::REG_ALARM_LEVEL: begin
          alarm_level_r <= cfg_data[uvsa_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      taken_r <= '0;
    end else if (cmd.clear || cmd.start_avg) begin
      acc_r   <= '0;
      taken_r <= '0;
    end else if (cmd.accum) begin
      acc_r   <= sum;
      taken_r <= taken_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_avg) begin
      dvd_r <= uvsa_pkg::DIV_W'(sum);
      rem_r <= '0;
      dsr_r <= uvsa_pkg::DEN_W'(eff_count);
    end else if (cmd.scale) begin
      avg_r <= avg_clamped;
      uvi_r <= uv_clamped;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[uvsa_pkg::DIV_W-2:0], trial_ge};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ok) begin
      avg_q_r    <= avg_r;
      uv_q_r     <= uvi_r;
      alert_q_r  <= (uvi_r >= alarm_level_r);
      failed_q_r <= 1'b0;
    end else if (cmd.emit_fail) begin
      avg_q_r    <= '0;
      uv_q_r     <= '0;
      alert_q_r  <= 1'b0;
      failed_q_r <= 1'b1;
    end
  end

  assign out_average_raw = avg_q_r;
  assign out_uvi         = uv_q_r;
  assign out_alert       = alert_q_r;
  assign out_failed      = failed_q_r;

endmodule
`default_nettype wire

>>> rtl/uvsa_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module uvsa_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  uvsa_pkg::status_t  sts,
  output uvsa_pkg::cmd_t     cmd
);

  uvsa_pkg::state_t              state_r;
  uvsa_pkg::state_t              state_nxt;
  logic [uvsa_pkg::STEP_W-1:0]   step_r;
  logic [uvsa_pkg::STEP_W-1:0]   step_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uvsa_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      uvsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!sts.sample_ok) begin
            cmd.clear = 1'b1;
            state_nxt = uvsa_pkg::ST_EMIT_FAIL;
          end else if (sts.group_done) begin
            cmd.start_avg = 1'b1;
            step_nxt      = '0;
            state_nxt     = uvsa_pkg::ST_DIV_AVG;
          end else begin
            cmd.accum = 1'b1;
          end
        end
      end
      uvsa_pkg::ST_DIV_AVG: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + uvsa_pkg::STEP_W'(1);
        if (step_r == uvsa_pkg::DIV_LAST) begin
          state_nxt = uvsa_pkg::ST_SCALE;
        end
      end
      uvsa_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        step_nxt  = '0;
        state_nxt = uvsa_pkg::ST_EMIT;
      end
      uvsa_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.emit_ok = 1'b1;
          state_nxt   = uvsa_pkg::ST_IDLE;
        end
      end
      uvsa_pkg::ST_EMIT_FAIL: begin
        if (out_free) begin
          cmd.emit_fail = 1'b1;
          state_nxt     = uvsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = uvsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit_ok || cmd.emit_fail) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_div_avg_runs, clk, rst_n,
    state_r == uvsa_pkg::ST_DIV_AVG && step_r != uvsa_pkg::DIV_LAST,
    state_r == uvsa_pkg::ST_DIV_AVG)
  `ASSERT_NEXT(a_scale_to_emit, clk, rst_n, state_r == uvsa_pkg::ST_SCALE,
    state_r == uvsa_pkg::ST_EMIT)
  `ASSERT_NEXT(a_emit_waits, clk, rst_n,
    (state_r == uvsa_pkg::ST_EMIT || state_r == uvsa_pkg::ST_EMIT_FAIL)
      && out_valid_r && !out_ready,
    $stable(state_r) && out_valid_r)
  `ASSERT_SAME(a_ready_only_idle, clk, rst_n, in_ready && in_valid,
    !(cmd.div_step || cmd.scale || cmd.emit_ok || cmd.emit_fail))

endmodule
`default_nettype wire
